/* rtl/core/srig_pkg.sv */
// Package for the stream reverse-in-groups unit.
// Holds the shared size constants and the shift control type of the cell chain.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srig_pkg;

  localparam int MAX_GROUP     = 16;
  localparam int ELEMENT_WIDTH = 32;
  localparam int CFG_W         = 5;

  // Shift command that every cell of the chain sees in the same cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } srig_shift_t;

endpackage

`default_nettype wire

/* rtl/core/srig_cell.sv */
// One cell of the element chain: holds a single element.
// Depends on srig_pkg for the shift control type.
`timescale 1ns / 1ps
`default_nettype none

module srig_cell #(
  parameter int ELEMENT_WIDTH = srig_pkg::ELEMENT_WIDTH
) (
  input  wire logic                     clk,
  input  wire srig_pkg::srig_shift_t    shift,
  input  wire logic [ELEMENT_WIDTH-1:0] from_prev,
  input  wire logic [ELEMENT_WIDTH-1:0] from_next,
  output logic      [ELEMENT_WIDTH-1:0] data
);

  logic [ELEMENT_WIDTH-1:0] data_r;
  logic [ELEMENT_WIDTH-1:0] data_nxt;

  // A push moves data away from the head, a pop moves it back toward the head.
  always_comb begin
    if (shift.push) begin
      data_nxt = from_prev;
    end else if (shift.pop) begin
      data_nxt = from_next;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

/* rtl/core/srig_chain.sv */
// Row of element cells working as a last-in first-out stack.
// Depends on srig_pkg and srig_cell.
`timescale 1ns / 1ps
`default_nettype none

module srig_chain #(
  parameter int MAX_GROUP     = srig_pkg::MAX_GROUP,
  parameter int ELEMENT_WIDTH = srig_pkg::ELEMENT_WIDTH
) (
  input  wire logic                     clk,
  input  wire srig_pkg::srig_shift_t    shift,
  input  wire logic [ELEMENT_WIDTH-1:0] push_data,
  output logic      [ELEMENT_WIDTH-1:0] head_data
);

  logic [ELEMENT_WIDTH-1:0] cell_data [MAX_GROUP];

  for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] prev_data;
    logic [ELEMENT_WIDTH-1:0] next_data;

    if (i == 0) begin : g_head
      assign prev_data = push_data;
    end else begin : g_body
      assign prev_data = cell_data[i-1];
    end

    // The deepest cell simply keeps its value on a pop.
    if (i == MAX_GROUP - 1) begin : g_tail
      assign next_data = cell_data[i];
    end else begin : g_inner
      assign next_data = cell_data[i+1];
    end

    srig_cell #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_cell (
      .clk      (clk),
      .shift    (shift),
      .from_prev(prev_data),
      .from_next(next_data),
      .data     (cell_data[i])
    );
  end

  assign head_data = cell_data[0];

endmodule

`default_nettype wire

/* rtl/core/stream_reverse_in_groups_unit.sv */
// Top level of the stream reverse-in-groups unit.
// Depends on srig_pkg and srig_chain (which instantiates srig_cell).
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  in_element, in_final_element
//   out_     output     out_valid/out_stall out_element_out, out_run_end, out_sequence_end
//   cfg_     input      cfg_valid/cfg_ready cfg_group_size
//
// While gathering, an input transfer pushes its element onto the head of the cell
// chain. When a group closes, its n elements are popped from the head one per
// cycle into the output register while the output is not stalled; input is stalled
// during this drain. Push and pop share the chain's single head, so no new element
// is taken until the group has drained. Reset is synchronous and clears the count,
// the drain state and the output valid. Output stalls hold the drain.
`timescale 1ns / 1ps
`default_nettype none

module stream_reverse_in_groups_unit #(
  parameter int MAX_GROUP     = srig_pkg::MAX_GROUP,
  parameter int ELEMENT_WIDTH = srig_pkg::ELEMENT_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [ELEMENT_WIDTH-1:0] in_element,
  input  wire logic                            in_final_element,

  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed      [ELEMENT_WIDTH-1:0] out_element_out,
  output logic                                 out_run_end,
  output logic                                 out_sequence_end,

  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [srig_pkg::CFG_W-1:0]      cfg_group_size
);

  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int CMP_W = (CNT_W > srig_pkg::CFG_W) ? CNT_W : srig_pkg::CFG_W;

  logic [srig_pkg::CFG_W-1:0] group_size_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           cnt_nxt;
  logic [CNT_W-1:0]           cnt_inc;
  logic                       drain_r;
  logic                       drain_nxt;
  logic                       last_r;
  logic                       last_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [ELEMENT_WIDTH-1:0]   out_element_r;
  logic                       out_run_end_r;
  logic                       out_sequence_end_r;

  logic                       in_xfer;
  logic                       pop_go;
  logic                       group_done;
  logic [ELEMENT_WIDTH-1:0]   head_data;
  srig_pkg::srig_shift_t      shift;

  assign cfg_ready = 1'b1;
  assign in_stall  = drain_r;
  assign in_xfer   = in_valid && !drain_r;
  assign pop_go    = drain_r && (!out_valid_r || !out_stall);

  assign cnt_inc = CNT_W'(cnt_r + 1'b1);

  // A group size of zero always closes here, since the count is at least one.
  // Sizes above the chain depth close when the chain is full.
  assign group_done = in_final_element
                   || (CMP_W'(cnt_inc) >= CMP_W'(group_size_r))
                   || (cnt_inc == CNT_W'(MAX_GROUP));

  assign shift.push = in_xfer;
  assign shift.pop  = pop_go;

  srig_chain #(
    .MAX_GROUP    (MAX_GROUP),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_chain (
    .clk      (clk),
    .shift    (shift),
    .push_data(in_element),
    .head_data(head_data)
  );

  always_comb begin
    cnt_nxt       = cnt_r;
    drain_nxt     = drain_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      cnt_nxt = cnt_inc;
      if (group_done) begin
        drain_nxt = 1'b1;
        last_nxt  = in_final_element;
      end
    end else if (pop_go) begin
      cnt_nxt       = CNT_W'(cnt_r - 1'b1);
      out_valid_nxt = 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        drain_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= srig_pkg::CFG_W'(1);
      cnt_r        <= '0;
      drain_r      <= 1'b0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        group_size_r <= cfg_group_size;
      end
      cnt_r       <= cnt_nxt;
      drain_r     <= drain_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_go) begin
      out_element_r      <= head_data;
      out_run_end_r      <= (cnt_r == CNT_W'(1));
      out_sequence_end_r <= (cnt_r == CNT_W'(1)) && last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_element_out  = out_element_r;
  assign out_run_end      = out_run_end_r;
  assign out_sequence_end = out_sequence_end_r;

endmodule

`default_nettype wire

/* tb/tb_stream_reverse_in_groups_unit.sv */
// Testbench for stream_reverse_in_groups_unit: group-reversal of a signed element stream.
// A clocked driver and monitor run against a behavioral predictor of the reversal.
// Depends on srig_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_stream_reverse_in_groups_unit;

  localparam int EW            = srig_pkg::ELEMENT_WIDTH;
  localparam int GROUP_MAX     = srig_pkg::MAX_GROUP;
  localparam int SETTLE_CYCLES = 2 * GROUP_MAX + 8;

  localparam logic signed [EW-1:0] ELEM_MIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [EW-1:0] ELEM_MAX = {1'b0, {(EW-1){1'b1}}};

  typedef struct {
    logic signed [EW-1:0] element;
    logic                 last_of_seq;
  } seq_element_t;

  typedef struct {
    logic signed [EW-1:0] element;
    logic                 run_end;
    logic                 sequence_end;
  } reversed_out_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [EW-1:0] in_element = '0;
  logic                 in_final_element = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [EW-1:0] out_element_out;
  logic                 out_run_end;
  logic                 out_sequence_end;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [srig_pkg::CFG_W-1:0]    cfg_group_size = '0;

  // Predictor state: its own copy of the register, the store and the fill count.
  logic [srig_pkg::CFG_W-1:0] group_size_reg = 5'd1;
  logic signed [EW-1:0]       held_elements [GROUP_MAX];
  int unsigned                held_count = 0;

  seq_element_t  pending_elements [$];
  reversed_out_t expected_reversed [$];
  int            items_left = 0;
  int            error_count = 0;
  int            in_gap_pct = 37;
  int            out_stall_pct = 37;

  seq_element_t  staged;
  reversed_out_t wanted;

  stream_reverse_in_groups_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element       (in_element),
    .in_final_element (in_final_element),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_element_out  (out_element_out),
    .out_run_end      (out_run_end),
    .out_sequence_end (out_sequence_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_group_size   (cfg_group_size)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stores one accepted element and, when the group closes, queues the
  // group's elements newest first.
  function automatic void reverse_on_accept(input logic signed [EW-1:0] elem,
                                            input logic fin);
    int unsigned   span;
    reversed_out_t r;
    if (group_size_reg == 0)
      span = 1;
    else if (group_size_reg > GROUP_MAX)
      span = GROUP_MAX;
    else
      span = group_size_reg;
    if (held_count < GROUP_MAX) begin
      held_elements[held_count] = elem;
      held_count++;
    end
    if (held_count < span && !fin)
      return;
    for (int k = 0; k < held_count; k++) begin
      r.element      = held_elements[held_count - 1 - k];
      r.run_end      = (k + 1 == held_count);
      r.sequence_end = r.run_end && fin;
      expected_reversed.push_back(r);
    end
    held_count = 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reverse_on_accept(in_element, in_final_element);
        items_left--;
      end
      // A stalled transfer keeps its valid and payload until it is taken.
      if (!in_valid || !in_stall) begin
        if (pending_elements.size() != 0 && $urandom_range(99) >= in_gap_pct) begin
          staged = pending_elements.pop_front();
          in_element       <= staged.element;
          in_final_element <= staged.last_of_seq;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reversed.size() == 0) begin
          $error("unexpected output transfer: element_out %0d", out_element_out);
          error_count++;
        end else begin
          wanted = expected_reversed.pop_front();
          if (out_element_out !== wanted.element) begin
            $error("element_out: expected %0d, got %0d", wanted.element, out_element_out);
            error_count++;
          end
          if (out_run_end !== wanted.run_end) begin
            $error("run_end: expected %0b, got %0b", wanted.run_end, out_run_end);
            error_count++;
          end
          if (out_sequence_end !== wanted.sequence_end) begin
            $error("sequence_end: expected %0b, got %0b", wanted.sequence_end,
                   out_sequence_end);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  task automatic queue_element(input logic signed [EW-1:0] elem, input logic fin);
    seq_element_t s;
    s.element     = elem;
    s.last_of_seq = fin;
    pending_elements.push_back(s);
    items_left++;
  endtask

  // Holds the sender back until every queued element is taken and every
  // expected result has arrived, then lets a group still being gathered settle.
  task automatic wait_drained;
    do @(posedge clk); while (items_left != 0 || expected_reversed.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_group_size(input logic [srig_pkg::CFG_W-1:0] sz);
    cfg_group_size <= sz;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid      <= 1'b0;
    group_size_reg = sz;
  endtask

  // Well-formed sequences of random length; with leave_open the phase ends in
  // the middle of a sequence so that a partial group stays in the store.
  task automatic run_random_phase(input logic [srig_pkg::CFG_W-1:0] sz, input int count,
                                  input bit leave_open, input int gap_pct,
                                  input int stall_pct);
    int                   remaining;
    logic signed [EW-1:0] e;
    logic                 fin;
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    write_group_size(sz);
    remaining = 0;
    for (int pos = 1; pos <= count; pos++) begin
      if (remaining == 0)
        remaining = $urandom_range(1, 40);
      case ($urandom_range(15))
        0:       e = ELEM_MIN;
        1:       e = ELEM_MAX;
        2:       e = '0;
        3:       e = -1;
        default: e = $urandom;
      endcase
      remaining--;
      fin = (pos == count) ? !leave_open : (remaining == 0);
      queue_element(e, fin);
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A size of zero behaves as one: every element passes straight through.
    write_group_size(5'd0);
    queue_element(ELEM_MIN, 1'b0);
    queue_element(ELEM_MAX, 1'b1);
    wait_drained();

    // Full group closed by the final element, then short trailing groups.
    write_group_size(5'd3);
    queue_element('0, 1'b0);
    queue_element(-1, 1'b0);
    queue_element(1, 1'b1);
    queue_element(5, 1'b0);
    queue_element(6, 1'b0);
    queue_element(7, 1'b0);
    queue_element(ELEM_MAX, 1'b1);
    queue_element(ELEM_MIN, 1'b0);
    queue_element(-2, 1'b1);
    wait_drained();

    // Lowering the size with five elements held: the next transfer flushes six.
    write_group_size(5'd8);
    for (int i = 0; i < 5; i++)
      queue_element($urandom, 1'b0);
    wait_drained();
    write_group_size(5'd2);
    queue_element(ELEM_MIN, 1'b0);
    queue_element(ELEM_MAX, 1'b1);
    wait_drained();

    write_group_size(5'd1);
    queue_element(-1, 1'b0);
    queue_element(ELEM_MIN, 1'b1);
    wait_drained();

    run_random_phase(5'd16, 35, 1'b0, 37, 37);
    run_random_phase(5'd31, 35, 1'b1, 37, 37);
    run_random_phase(5'd4,  35, 1'b1, 37, 37);
    run_random_phase(5'd0,  35, 1'b0, 37, 37);
    run_random_phase(5'd7,  60, 1'b0, 0, 0);
    run_random_phase(5'd12, 35, 1'b1, 37, 37);
    run_random_phase(5'd1,  35, 1'b0, 37, 37);
    run_random_phase(5'($urandom_range(17, 31)), 35, 1'b1, 37, 37);
    run_random_phase(5'($urandom_range(2, 15)),  35, 1'b0, 37, 37);

    if (error_count == 0) begin
      $display("tb_stream_reverse_in_groups_unit: clean");
    end else begin
      $display("tb_stream_reverse_in_groups_unit: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_stream_reverse_in_groups_unit: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/core/srig_pkg.sv
rtl/core/srig_cell.sv
rtl/core/srig_chain.sv
rtl/core/stream_reverse_in_groups_unit.sv
tb/tb_stream_reverse_in_groups_unit.sv
